// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the sentence checker.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, ignored while reset is asserted (active low).
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on every rising edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/nsc_pkg.sv -----
// Shared types, constants and helper functions for the sentence checker.
// No dependencies.
package nsc_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int TAG_LEN   = 6;
    localparam int WINDOW_W  = (TAG_LEN - 1) * BYTE_W;
    localparam int DIGIT_W   = 5;
    localparam int RESULT_W  = KIND_W + 2 * BYTE_W;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0]         STAR_CHAR = 8'h2A;
    localparam logic [DIGIT_W-1:0]        HEX_RADIX = 5'd16;
    localparam logic [TAG_LEN*BYTE_W-1:0] TAG_GGA   = "$GPGGA";
    localparam logic [TAG_LEN*BYTE_W-1:0] TAG_RMC   = "$GPRMC";

    localparam logic [KIND_W-1:0] KIND_GGA     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RMC     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SUM_ERR = 2'd3;

    typedef struct packed {
        logic gga;
        logic rmc;
    } tag_hits_t;

    // Digit value 0..15, or HEX_RADIX when the byte is not a hex digit.
    function automatic logic [DIGIT_W-1:0] hex_digit(input logic [BYTE_W-1:0] b);
        logic [DIGIT_W-1:0] d;
        d = HEX_RADIX;
        if (b inside {["0":"9"]}) begin
            d = {1'b0, b[3:0]};
        end else if (b inside {["A":"F"], ["a":"f"]}) begin
            d = {1'b0, b[3:0] + 4'd9};
        end
        return d;
    endfunction

endpackage

// ----- hw/rtl/nsc_tag_window.sv -----
// Sliding six-byte window that records whether either sentence tag occurred.
// Depends on nsc_pkg.
module nsc_tag_window (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic                       clear,
    input  logic [nsc_pkg::BYTE_W-1:0] cur_byte,
    output nsc_pkg::tag_hits_t         hits
);
    import nsc_pkg::*;

    logic [WINDOW_W-1:0] window_reg;
    tag_hits_t           seen_reg;

    // Include the byte now being consumed so the verdict sees a tag ending on it.
    always_comb begin
        hits.gga = seen_reg.gga || ({window_reg, cur_byte} == TAG_GGA);
        hits.rmc = seen_reg.rmc || ({window_reg, cur_byte} == TAG_RMC);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            seen_reg   <= '0;
        end else if (advance) begin
            if (clear) begin
                window_reg <= '0;
                seen_reg   <= '0;
            end else begin
                window_reg <= {window_reg[WINDOW_W-BYTE_W-1:0], cur_byte};
                seen_reg   <= hits;
            end
        end
    end

endmodule

// ----- hw/rtl/nmea_sentence_checker_unit.sv -----
// Top level of the NMEA sentence checker: input register, checksum state, verdict register.
// Depends on nsc_pkg, nsc_tag_window and assert_macros.svh.
//
// Usage:
//   Feed one sentence byte per request on the s_ channel; s_tlast marks the final
//   byte (end of sentence). For each final byte one verdict request appears on the
//   m_ channel carrying the message kind, the XOR sum computed over the bytes after
//   the first one up to '*', and the hex checksum read after '*'. Other bytes
//   produce no output.
//   Throughput: one byte per cycle while no final byte waits for the output slot,
//   set by the single update of the running state per cycle. A final byte accepted
//   is captured in the input register; once it is consumed, its verdict shows on m_tvalid.
//   The output register separates both sides: while a verdict waits, bytes that are
//   not final keep flowing; a final byte holds in the input register until the
//   output slot frees, and s_tready drops only then.
//   Reset (aresetn low, synchronous) empties both registers and returns the sentence
//   state to its start: first byte pending, no star, sums zero, tag window zero.
//   After each verdict the state clears the same way for the next sentence.
`include "assert_macros.svh"

module nmea_sentence_checker_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nsc_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] sentence_byte
    input  logic                          s_tlast,   // end_of_sentence
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nsc_pkg::M_TDATA_W-1:0] m_tdata    // [1:0] message_kind,
                                                     // [9:2] computed_sum,
                                                     // [17:10] received_sum, rest zero
);
    import nsc_pkg::*;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Sentence state
    logic              first_pending_reg, first_pending_next;
    logic              star_seen_reg,     star_seen_next;
    logic              number_closed_reg, number_closed_next;
    logic [BYTE_W-1:0] xor_total_reg,     xor_total_next;
    logic [BYTE_W-1:0] hex_value_reg,     hex_value_next;
    logic              hex_overflow_reg,  hex_overflow_next;

    // Result register
    logic              m_valid_reg;
    logic [KIND_W-1:0] kind_reg,     kind_next;
    logic [BYTE_W-1:0] comp_sum_reg;
    logic [BYTE_W-1:0] recv_sum_reg;

    logic               out_free;
    logic               advance;
    logic [DIGIT_W-1:0] digit;
    tag_hits_t          hits;

    // A final byte needs the output slot; other bytes advance whenever present.
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({recv_sum_reg, comp_sum_reg, kind_reg});

    assign digit = hex_digit(in_byte_reg);

    nsc_tag_window u_tag_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .clear    (in_last_reg),
        .cur_byte (in_byte_reg),
        .hits     (hits)
    );

    // Next sentence state for the byte in the input register.
    always_comb begin
        first_pending_next = 1'b0;
        star_seen_next     = star_seen_reg;
        number_closed_next = number_closed_reg;
        xor_total_next     = xor_total_reg;
        hex_value_next     = hex_value_reg;
        hex_overflow_next  = hex_overflow_reg;
        if (first_pending_reg) begin
            // skip the leading byte
        end else if (!star_seen_reg) begin
            if (in_byte_reg == STAR_CHAR) begin
                star_seen_next = 1'b1;
            end else begin
                xor_total_next = xor_total_reg ^ in_byte_reg;
            end
        end else if (!number_closed_reg) begin
            if (digit == HEX_RADIX) begin
                number_closed_next = 1'b1;
            end else begin
                // shifting out a nonzero high nibble means the value passed 255
                if (hex_value_reg[7:4] != 4'd0) begin
                    hex_overflow_next = 1'b1;
                end
                hex_value_next = {hex_value_reg[3:0], digit[3:0]};
            end
        end
    end

    // Verdict: a checksum error outranks any tag, GGA outranks RMC.
    always_comb begin
        if (!star_seen_next || hex_overflow_next || (xor_total_next != hex_value_next)) begin
            kind_next = KIND_SUM_ERR;
        end else if (hits.gga) begin
            kind_next = KIND_GGA;
        end else if (hits.rmc) begin
            kind_next = KIND_RMC;
        end else begin
            kind_next = KIND_UNKNOWN;
        end
    end

    // Input register: load on every accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Sentence state: advance per byte, clear after the final byte.
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            first_pending_reg <= 1'b1;
            star_seen_reg     <= 1'b0;
            number_closed_reg <= 1'b0;
            xor_total_reg     <= '0;
            hex_value_reg     <= '0;
            hex_overflow_reg  <= 1'b0;
        end else if (advance) begin
            first_pending_reg <= first_pending_next;
            star_seen_reg     <= star_seen_next;
            number_closed_reg <= number_closed_next;
            xor_total_reg     <= xor_total_next;
            hex_value_reg     <= hex_value_next;
            hex_overflow_reg  <= hex_overflow_next;
        end
    end

    // Result register: hold until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            kind_reg     <= kind_next;
            comp_sum_reg <= xor_total_next;
            recv_sum_reg <= hex_value_next;
        end
    end

    // A consumed final byte yields a verdict on the next cycle.
    `ASSERT_RST(a_verdict_follows_last, aclk, aresetn,
        advance && in_last_reg |=> m_valid_reg, "final byte produced no verdict")
    // The sentence state starts over after a verdict.
    `ASSERT_RST(a_state_cleared, aclk, aresetn,
        advance && in_last_reg |=> first_pending_reg && !star_seen_reg && !hex_overflow_reg,
        "sentence state not cleared after verdict")
    // A verdict other than checksum error implies matching sums.
    `ASSERT_RST(a_kind_sums_agree, aclk, aresetn,
        m_valid_reg && (kind_reg != KIND_SUM_ERR) |-> comp_sum_reg == recv_sum_reg,
        "tag verdict with mismatching checksum")
    // A waiting verdict is never overwritten by the next final byte.
    `ASSERT_RST(a_no_overwrite, aclk, aresetn,
        m_valid_reg && !m_tready |-> !(advance && in_last_reg),
        "pending verdict overwritten")

endmodule
